// File: design/gsf_pkg.sv
// Shared types, constants and the weight table of the Gaussian smoothing filter.
package gsf_pkg;

    // Width of a window position; holds any window length up to 31.
    localparam int POS_W = 5;
    // Width of a tap index; holds any half-window up to 15.
    localparam int TAP_W = 4;
    // Width of a sample and of a smoothed result.
    localparam int BYTE_W = 8;

    // Gaussian weights in Q0.16, round(65536*exp(-k*k/64)/(8*sqrt(2*pi))).
    localparam logic [11:0] GAUSS_Q16 [16] = '{
        12'd3268, 12'd3217, 12'd3070, 12'd2839, 12'd2545, 12'd2211, 12'd1862, 12'd1520,
        12'd1202, 12'd922,  12'd685,  12'd493,  12'd344,  12'd233,  12'd153,  12'd97
    };

    typedef struct packed {
        logic [BYTE_W-1:0] sample;
        logic              end_of_set;
    } raw_t;

    typedef struct packed {
        logic [BYTE_W-1:0] smoothed;
        logic              run_last;
        logic              set_last;
    } res_t;

    // Two window positions read in the same cycle.
    typedef struct packed {
        logic [POS_W-1:0] pos_lo;
        logic [POS_W-1:0] pos_hi;
    } win_rd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_TAP,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PUSH
    } state_t;

    // Weight of tap k scaled to the given number of fraction bits.
    function automatic logic [31:0] weight_at(input logic [TAP_W-1:0] k, input int frac);
        logic [31:0] w;
        w = {20'd0, GAUSS_Q16[k]};
        if (frac >= 16)
        begin
            weight_at = w << (frac - 16);
        end
        else
        begin
            weight_at = (w + (32'd1 << (15 - frac))) >> (16 - frac);
        end
    endfunction

endpackage

// File: design/gsf_window.sv
// Sample window store: a circular buffer with one write port and two registered read ports.
module gsf_window #(
    parameter int WIN_LEN = 21
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [gsf_pkg::BYTE_W-1:0]       wr_data,
    input  logic                             restart,
    input  gsf_pkg::win_rd_t                 rd,
    output logic [gsf_pkg::BYTE_W-1:0]       rd_lo,
    output logic [gsf_pkg::BYTE_W-1:0]       rd_hi,
    output logic                             full
);

    localparam int IW = $clog2(WIN_LEN);
    localparam int CW = $clog2(WIN_LEN + 1);
    localparam int SUM_W = gsf_pkg::POS_W + 1;

    logic [gsf_pkg::BYTE_W-1:0] mem [WIN_LEN];

    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] base_reg, base_next;
    logic [IW-1:0] wr_idx;
    logic [SUM_W-1:0] sum_lo, sum_hi, phys_lo, phys_hi;
    logic [gsf_pkg::BYTE_W-1:0] rd_lo_reg, rd_hi_reg;

    assign full = (count_reg == CW'(WIN_LEN));

    // Before the window fills the oldest sample sits at physical zero; once full,
    // each new sample overwrites the oldest and the base advances.
    assign wr_idx = full ? base_reg : count_reg[IW-1:0];

    always_comb
    begin
        count_next = count_reg;
        base_next  = base_reg;
        if (restart)
        begin
            count_next = '0;
            base_next  = '0;
        end
        else if (wr_en)
        begin
            if (!full)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (base_reg == IW'(WIN_LEN - 1))
            begin
                base_next = '0;
            end
            else
            begin
                base_next = base_reg + IW'(1);
            end
        end
    end

    always_comb
    begin
        sum_lo  = SUM_W'(base_reg) + SUM_W'(rd.pos_lo);
        sum_hi  = SUM_W'(base_reg) + SUM_W'(rd.pos_hi);
        phys_lo = (sum_lo >= SUM_W'(WIN_LEN)) ? sum_lo - SUM_W'(WIN_LEN) : sum_lo;
        phys_hi = (sum_hi >= SUM_W'(WIN_LEN)) ? sum_hi - SUM_W'(WIN_LEN) : sum_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            base_reg  <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_lo_reg <= mem[phys_lo[IW-1:0]];
        rd_hi_reg <= mem[phys_hi[IW-1:0]];
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

endmodule

// File: design/gsf_div.sv
// Restoring divider that produces an 8-bit quotient, one bit per cycle.
module gsf_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            dividend,
    input  logic [DEN_W-1:0]            divisor,
    output logic                        busy,
    output logic [gsf_pkg::BYTE_W-1:0]  quotient
);

    localparam int QW = gsf_pkg::BYTE_W;
    localparam int NW = $clog2(QW);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             fits;

    // The quotient is known to stay below 2**QW, so the divisor starts shifted
    // up by QW-1 places and moves down one place per step.
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend;
            dsh_next  = NUM_W'(divisor) << (QW - 1);
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[QW-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(QW - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// File: design/gaussian_smoothing_filter.sv
// Top level of the Gaussian smoothing filter: sequencer, shared multiply-accumulate and output register.
//
// Usage: raw samples arrive on the raw channel (raw_valid, raw_stall, raw_beat), one sample
// per beat, with end_of_set marking the final sample of a data set. Smoothed bytes leave on
// the res channel (res_valid, res_stall, res_beat). A beat moves when valid is high and stall
// is low at a rising clock edge.
// Once 2*HALF_WINDOW+1 samples of a set are in, the first HALF_WINDOW+1 results leave as a
// burst; after that each sample yields one result, and the final sample of the set also releases
// the remaining HALF_WINDOW results. A set shorter than the window yields nothing.
// Each result is computed by one multiply-accumulate unit that walks the taps of the window
// (reach+1 taps, reach being at most HALF_WINDOW), then a restoring divide (a start state,
// eight quotient steps and a wait state that sees it finish), plus setup, drain and hand-off
// states. A sample that yields results occupies the block until its last result is handed
// off; raw_stall is high while the block works on a sample.
// The finished result sits in an output register, so the next sample is taken while it waits.
// If the receiver stalls, the sequencer holds the next finished result until the register
// frees up. Reset empties the window and the output register; no clearing pass is needed.
module gaussian_smoothing_filter #(
    parameter int HALF_WINDOW      = 10,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           raw_valid,
    output logic           raw_stall,
    input  gsf_pkg::raw_t  raw_beat,
    output logic           res_valid,
    input  logic           res_stall,
    output gsf_pkg::res_t  res_beat
);

    localparam int POS_W   = gsf_pkg::POS_W;
    localparam int TAP_W   = gsf_pkg::TAP_W;
    localparam int BYTE_W  = gsf_pkg::BYTE_W;
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    // Weight width: 12 bits cover the Q0.16 table; more fraction bits widen it.
    localparam int WW      = (WEIGHT_FRAC_BITS > 16) ? WEIGHT_FRAC_BITS - 4 : 12;
    // The weight sum covers at most 31 weights, the accumulator 255 times that.
    localparam int SW      = WW + 5;
    localparam int AW      = SW + BYTE_W;
    localparam int PW      = BYTE_W + 1 + WW;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WIN_LEN - 1);
    localparam logic [POS_W-1:0] HALF_POS = POS_W'(HALF_WINDOW);

    gsf_pkg::state_t state_reg, state_next;

    logic             last_reg, last_next;
    logic [POS_W-1:0] p_reg, p_next;
    logic [POS_W-1:0] stop_reg, stop_next;
    logic [POS_W-1:0] nxt_pos_reg, nxt_pos_next;
    logic [TAP_W-1:0] reach_reg, reach_next;
    logic [TAP_W-1:0] j_reg, j_next;
    logic [TAP_W-1:0] tap_j_reg, tap_j_next;
    logic             tap_vld_reg, tap_vld_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [SW-1:0]    wsum_reg, wsum_next;
    logic             out_valid_reg, out_valid_next;
    gsf_pkg::res_t    out_reg, out_next;

    // Sequencer outputs.
    logic accept;
    logic win_restart;
    logic div_start;
    logic issue;
    logic can_push;
    logic push;
    logic at_stop;

    // Window and datapath.
    gsf_pkg::win_rd_t   win_rd;
    logic [BYTE_W-1:0]  rd_lo, rd_hi;
    logic               win_full;
    logic               div_busy;
    logic [BYTE_W-1:0]  div_q;
    logic [31:0]        weight_full;
    logic [WW-1:0]      weight;
    logic [BYTE_W:0]    pair;
    logic [PW-1:0]      product;
    logic [SW-1:0]      wadd;
    logic [POS_W-1:0]   right_gap;
    logic [POS_W-1:0]   reach_min;

    gsf_window #(
        .WIN_LEN (WIN_LEN)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (raw_beat.sample),
        .restart (win_restart),
        .rd      (win_rd),
        .rd_lo   (rd_lo),
        .rd_hi   (rd_hi),
        .full    (win_full)
    );

    gsf_div #(
        .NUM_W (AW),
        .DEN_W (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (wsum_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gsf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gsf_pkg::ST_CHECK;
                end
            end
            gsf_pkg::ST_CHECK:
            begin
                state_next = win_full ? gsf_pkg::ST_SETUP : gsf_pkg::ST_IDLE;
            end
            gsf_pkg::ST_SETUP:
            begin
                state_next = gsf_pkg::ST_TAP;
            end
            gsf_pkg::ST_TAP:
            begin
                if (j_reg == reach_reg)
                begin
                    state_next = gsf_pkg::ST_DRAIN;
                end
            end
            gsf_pkg::ST_DRAIN:
            begin
                state_next = gsf_pkg::ST_DIV_GO;
            end
            gsf_pkg::ST_DIV_GO:
            begin
                state_next = gsf_pkg::ST_DIV_WAIT;
            end
            gsf_pkg::ST_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    state_next = gsf_pkg::ST_PUSH;
                end
            end
            gsf_pkg::ST_PUSH:
            begin
                if (can_push)
                begin
                    state_next = at_stop ? gsf_pkg::ST_IDLE : gsf_pkg::ST_SETUP;
                end
            end
            default:
            begin
                state_next = gsf_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer: control outputs.
    always_comb
    begin
        raw_stall   = (state_reg != gsf_pkg::ST_IDLE);
        accept      = raw_valid && (state_reg == gsf_pkg::ST_IDLE);
        can_push    = !out_valid_reg || !res_stall;
        at_stop     = (p_reg == stop_reg);
        issue       = (state_reg == gsf_pkg::ST_TAP);
        div_start   = (state_reg == gsf_pkg::ST_DIV_GO);
        push        = (state_reg == gsf_pkg::ST_PUSH) && can_push;
        // A set ends either without a full window (discarded) or after its last result.
        win_restart = ((state_reg == gsf_pkg::ST_CHECK) && !win_full && last_reg)
                      || (push && at_stop && last_reg);
    end

    // Tap addresses: the pair of samples at distance j on either side of p.
    always_comb
    begin
        win_rd.pos_lo = p_reg - POS_W'(j_reg);
        win_rd.pos_hi = p_reg + POS_W'(j_reg);
    end

    // Shared multiply-accumulate on the pair read in the previous cycle.
    always_comb
    begin
        weight_full = gsf_pkg::weight_at(tap_j_reg, WEIGHT_FRAC_BITS);
        weight      = weight_full[WW-1:0];
        pair        = (BYTE_W + 1)'(rd_lo)
                      + ((tap_j_reg == '0) ? '0 : (BYTE_W + 1)'(rd_hi));
        product     = PW'(pair) * PW'(weight);
        wadd        = (tap_j_reg == '0) ? SW'(weight) : (SW'(weight) << 1);
    end

    // Reach shrinks toward either edge of the window.
    always_comb
    begin
        right_gap = LAST_POS - p_reg;
        reach_min = HALF_POS;
        if (p_reg < reach_min)
        begin
            reach_min = p_reg;
        end
        if (right_gap < reach_min)
        begin
            reach_min = right_gap;
        end
    end

    // Datapath next values.
    always_comb
    begin
        last_next      = last_reg;
        p_next         = p_reg;
        stop_next      = stop_reg;
        nxt_pos_next   = nxt_pos_reg;
        reach_next     = reach_reg;
        j_next         = j_reg;
        tap_j_next     = j_reg;
        tap_vld_next   = issue;
        acc_next       = acc_reg;
        wsum_next      = wsum_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (accept)
        begin
            last_next = raw_beat.end_of_set;
        end

        if ((state_reg == gsf_pkg::ST_CHECK) && win_full)
        begin
            p_next    = nxt_pos_reg;
            stop_next = last_reg ? LAST_POS : HALF_POS;
        end

        if (state_reg == gsf_pkg::ST_SETUP)
        begin
            reach_next = reach_min[TAP_W-1:0];
            j_next     = '0;
            acc_next   = '0;
            wsum_next  = '0;
        end

        if (issue)
        begin
            j_next = j_reg + TAP_W'(1);
        end

        if (tap_vld_reg)
        begin
            acc_next  = acc_reg + AW'(product);
            wsum_next = wsum_reg + wadd;
        end

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (push)
        begin
            out_valid_next    = 1'b1;
            out_next.smoothed = div_q;
            out_next.run_last = at_stop;
            out_next.set_last = last_reg && (p_reg == LAST_POS);
            if (at_stop)
            begin
                nxt_pos_next = last_reg ? '0 : HALF_POS;
            end
            else
            begin
                p_next = p_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsf_pkg::ST_IDLE;
            nxt_pos_reg   <= '0;
            tap_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nxt_pos_reg   <= nxt_pos_next;
            tap_vld_reg   <= tap_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        p_reg     <= p_next;
        stop_reg  <= stop_next;
        reach_reg <= reach_next;
        j_reg     <= j_next;
        tap_j_reg <= tap_j_next;
        acc_reg   <= acc_next;
        wsum_reg  <= wsum_next;
        out_reg   <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res_beat  = out_reg;

endmodule
